### design/dcrb_pkg.sv
// dcrb_pkg: constants, codes and types shared by the dma channel register block
// no dependencies
`default_nettype none

package dcrb_pkg;

  localparam int unsigned CHANNELS     = 8;
  localparam int unsigned WORDS_PER_CH = 8;
  localparam int unsigned DEPTH        = CHANNELS * WORDS_PER_CH;
  localparam int unsigned CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned WIDX_W       = $clog2(DEPTH);
  localparam int unsigned STATUS_W     = 24;
  localparam int unsigned ABORT_LSB    = 8;
  localparam int unsigned DONE_LSB     = 16;

  localparam logic [8:0] OFF_CTRL   = 9'h020;
  localparam logic [8:0] OFF_ABORT  = 9'h024;
  localparam logic [8:0] OFF_ROUTE0 = 9'h028;
  localparam logic [8:0] OFF_ROUTE1 = 9'h02C;
  localparam logic [8:0] OFF_STATUS = 9'h030;
  localparam logic [8:0] CH_BASE    = 9'h040;
  localparam logic [9:0] CH_END     = 10'(10'h040 + CHANNELS * 32'h20);

  localparam logic [2:0] WORD_CTRL = 3'd0;
  localparam logic [2:0] WORD_SIZE = 3'd1;
  localparam logic [2:0] WORD_DST  = 3'd4;

  localparam logic [31:0] ROUTE_RESET = 32'h7654_3210;
  localparam logic [31:0] WIN_A_LO    = 32'h2000_0000;
  localparam logic [31:0] WIN_A_HI    = 32'h2000_C000;
  localparam logic [31:0] WIN_B_LO    = 32'h4012_0000;
  localparam logic [31:0] WIN_B_HI    = 32'h4012_A000;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       err;
    logic [3:0] cnt;
  } xfer_t;

endpackage

`default_nettype wire

### design/dma_channel_register_block_top.sv
// dma_channel_register_block_top: bus access pipeline, global registers and status
// depends on dcrb_pkg, dcrb_chmem, dcrb_xfer
`default_nettype none

// Register block of an eight-channel descriptor DMA controller. One bus access
// (read or write, byte offset, write data) goes in per item and one item comes
// out with the read data and the interrupt line as it stands after the access.
// A new access is taken every cycle while the output is not stalled; each passes
// an input register then a result register, a pair set by the registered read
// port of the descriptor store. Reset is immediate: the store needs no clearing
// pass. Writing an enabled channel control word works out the transfer outcome
// at once; status is write-one-to-clear and irq is high while any flag is set.
module dma_channel_register_block_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [8:0]  offset_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_o
);
  import dcrb_pkg::*;

  logic                in_acc;
  logic                s1_valid_q;
  logic                s1_fire;
  cmd_e                s1_cmd_q;
  logic [8:0]          s1_off_q;
  logic [31:0]         s1_wdata_q;

  logic                out_valid_q;
  logic [31:0]         rdata_q;
  logic                irq_q;

  logic [31:0]         glob_q, glob_d;
  logic [31:0]         route0_q, route0_d;
  logic [31:0]         route1_q, route1_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [CHANNELS-1:0] en_q, en_d;
  logic [31:0]         size_q [CHANNELS];
  logic [31:0]         size_d [CHANNELS];
  logic [31:0]         dst_q  [CHANNELS];
  logic [31:0]         dst_d  [CHANNELS];
  logic [3:0]          cnt_q  [CHANNELS];
  logic [3:0]          cnt_d  [CHANNELS];

  logic [8:0]          rel_i;
  logic [8:0]          rel;
  logic                in_ch;
  logic [WIDX_W-1:0]   widx;
  logic [CH_W-1:0]     ch;
  logic [2:0]          word;
  logic                wr;
  logic [31:0]         mem_rd;
  logic                mem_we;
  logic                mem_clr;
  logic [31:0]         rdata;
  xfer_t               xfer;

  assign in_stall_o = s1_valid_q & out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign s1_fire    = s1_valid_q & (~out_valid_q | ~out_stall_i);

  assign rel_i = offset_i - CH_BASE;
  assign rel   = s1_off_q - CH_BASE;
  assign in_ch = (s1_off_q >= CH_BASE) && ({1'b0, s1_off_q} < CH_END);
  assign widx  = rel[WIDX_W+1:2];
  assign ch    = rel[CH_W+4:5];
  assign word  = rel[4:2];
  assign wr    = (s1_cmd_q == CMD_WRITE);

  dcrb_chmem u_chmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_idx_i  (rel_i[WIDX_W+1:2]),
    .wr_en_i   (s1_fire & mem_we),
    .wr_idx_i  (widx),
    .wr_data_i (s1_wdata_q),
    .clr_i     (s1_fire & mem_clr),
    .rd_data_o (mem_rd)
  );

  dcrb_xfer u_xfer (
    .ctrl_i (s1_wdata_q),
    .size_i (size_q[ch]),
    .dst_i  (dst_q[ch]),
    .res_o  (xfer)
  );

  always_comb begin
    rdata    = 32'd0;
    glob_d   = glob_q;
    route0_d = route0_q;
    route1_d = route1_q;
    status_d = status_q;
    en_d     = en_q;
    size_d   = size_q;
    dst_d    = dst_q;
    cnt_d    = cnt_q;
    mem_we   = 1'b0;
    mem_clr  = 1'b0;
    if (!wr) begin
      if (s1_off_q == OFF_CTRL) begin
        rdata = glob_q;
      end else if (s1_off_q == OFF_ROUTE0) begin
        rdata = route0_q;
      end else if (s1_off_q == OFF_ROUTE1) begin
        rdata = route1_q;
      end else if (s1_off_q == OFF_STATUS) begin
        rdata = {{(32-STATUS_W){1'b0}}, status_q};
      end else if (in_ch) begin
        rdata = mem_rd;
        if (word == WORD_CTRL) begin
          rdata[0] = en_q[ch];
        end
      end
    end else if (s1_off_q == OFF_CTRL) begin
      glob_d = s1_wdata_q;
      if (s1_wdata_q[0]) begin
        mem_clr = 1'b1;
        en_d    = '0;
        for (int c = 0; c < CHANNELS; c++) begin
          size_d[c] = 32'd0;
          dst_d[c]  = 32'd0;
        end
      end
    end else if (s1_off_q == OFF_ROUTE0) begin
      route0_d = s1_wdata_q;
    end else if (s1_off_q == OFF_ROUTE1) begin
      route1_d = s1_wdata_q;
    end else if (s1_off_q == OFF_ABORT) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (s1_wdata_q[c]) begin
          en_d[c]                = 1'b0;
          status_d[ABORT_LSB + c] = 1'b1;
        end
      end
    end else if (s1_off_q == OFF_STATUS) begin
      status_d = status_q & ~s1_wdata_q[STATUS_W-1:0];
    end else if (in_ch) begin
      mem_we = 1'b1;
      if (word == WORD_SIZE) begin
        size_d[ch] = s1_wdata_q;
      end
      if (word == WORD_DST) begin
        dst_d[ch] = s1_wdata_q;
      end
      if (word == WORD_CTRL) begin
        en_d[ch] = s1_wdata_q[0];
        if (rel[1:0] == 2'b00 && s1_wdata_q[0]) begin
          cnt_d[ch] = xfer.cnt;
          if (xfer.err) begin
            status_d[int'(ch)] = 1'b1;
          end
          status_d[DONE_LSB + int'(ch)] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= cmd_e'(command_i);
      s1_off_q   <= offset_i;
      s1_wdata_q <= write_data_i;
    end
    if (s1_fire) begin
      rdata_q <= rdata;
      irq_q   <= (status_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      glob_q      <= 32'd0;
      route0_q    <= ROUTE_RESET;
      route1_q    <= ROUTE_RESET;
      status_q    <= '0;
      en_q        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        size_q[c] <= 32'd0;
        dst_q[c]  <= 32'd0;
        cnt_q[c]  <= 4'd0;
      end
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        glob_q   <= glob_d;
        route0_q <= route0_d;
        route1_q <= route1_d;
        status_q <= status_d;
        en_q     <= en_d;
        size_q   <= size_d;
        dst_q    <= dst_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign irq_o       = irq_q;

  // pipeline only back-pressures while holding an item
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with no item held");

  // irq presented matches the status left by the access
  a_irq_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> irq_q == (status_q != '0))
    else $error("irq does not follow status");

  // global clear drops every enable
  a_global_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && wr && (s1_off_q == OFF_CTRL) && s1_wdata_q[0] |=> en_q == '0)
    else $error("enable survives global clear");

  // abort leaves the addressed channels disabled
  a_abort_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && wr && (s1_off_q == OFF_ABORT)
    |=> (en_q & $past(s1_wdata_q[CHANNELS-1:0])) == '0)
    else $error("aborted channel still enabled");

endmodule

`default_nettype wire

### design/dcrb_xfer.sv
// dcrb_xfer: closed-form transfer outcome of a channel start
// depends on dcrb_pkg
`default_nettype none

module dcrb_xfer (
  input  logic [31:0]    ctrl_i,
  input  logic [31:0]    size_i,
  input  logic [31:0]    dst_i,
  output dcrb_pkg::xfer_t res_o
);
  import dcrb_pkg::*;

  logic        unit4;
  logic [31:0] count;
  logic        in_a;
  logic        in_b;
  logic [31:0] win_end;
  logic [15:0] span;
  logic [16:0] span_up;
  logic [16:0] fit;
  logic        err;

  always_comb begin
    unit4   = ctrl_i[19] | ctrl_i[22];
    count   = size_i[31] ? 32'd0 : size_i;
    in_a    = (dst_i >= WIN_A_LO) && (dst_i < WIN_A_HI);
    in_b    = (dst_i >= WIN_B_LO) && (dst_i < WIN_B_HI);
    win_end = in_a ? WIN_A_HI : WIN_B_HI;
    span    = 16'(win_end - dst_i);
    span_up = {1'b0, span} + 17'd3;
    fit     = unit4 ? {2'b00, span_up[16:2]} : {1'b0, span};
    err     = (in_a | in_b) && (count != 32'd0) && (count > {15'd0, fit});
    res_o.err = err;
    res_o.cnt = err ? fit[3:0] : count[3:0];
  end

endmodule

`default_nettype wire

### design/dcrb_chmem.sv
// dcrb_chmem: channel descriptor word store with valid bits and write forwarding
// depends on dcrb_pkg
`default_nettype none

module dcrb_chmem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [dcrb_pkg::WIDX_W-1:0] rd_idx_i,
  input  logic                        wr_en_i,
  input  logic [dcrb_pkg::WIDX_W-1:0] wr_idx_i,
  input  logic [31:0]                 wr_data_i,
  input  logic                        clr_i,
  output logic [31:0]                 rd_data_o
);
  import dcrb_pkg::*;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        mem_q;
  logic [31:0]        fwd_q;
  logic               hit_q;
  logic [WIDX_W-1:0]  idx_q;
  logic [DEPTH-1:0]   valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_q <= mem[rd_idx_i];
      fwd_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= wr_en_i && (wr_idx_i == rd_idx_i);
        idx_q <= rd_idx_i;
      end
    end
  end

  assign rd_data_o = !valid_q[idx_q] ? 32'd0 : (hit_q ? fwd_q : mem_q);

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for the dma channel register block, random bus accesses
// a scoreboard class predicts read data and irq for each accepted access
// depends on dcrb_pkg and dma_channel_register_block_top

module tb;
  import dcrb_pkg::*;

  localparam int unsigned ITEMS      = 700;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] rd;
    logic        irq;
  } bus_resp_t;

  class dcrb_scoreboard;
    logic [31:0]         desc_words [DEPTH];
    logic [31:0]         glob_ctrl;
    logic [31:0]         route_words [2];
    logic [STATUS_W-1:0] status_bits;
    logic [3:0]          units_moved [CHANNELS];
    bus_resp_t           pending_resps [$];
    int unsigned         mismatches;

    function new();
      foreach (desc_words[i]) desc_words[i] = '0;
      foreach (units_moved[i]) units_moved[i] = '0;
      glob_ctrl      = '0;
      route_words[0] = ROUTE_RESET;
      route_words[1] = ROUTE_RESET;
      status_bits    = '0;
      mismatches     = 0;
    endfunction

    function logic [31:0] window_end(logic [31:0] addr);
      if (addr >= WIN_A_LO && addr < WIN_A_HI) return WIN_A_HI;
      if (addr >= WIN_B_LO && addr < WIN_B_HI) return WIN_B_HI;
      return '0;
    endfunction

    function void launch_transfer(int unsigned ch);
      logic [31:0] ctrl, size, dst, unit_bytes, count, lim, fit;
      ctrl = desc_words[ch * WORDS_PER_CH + WORD_CTRL];
      size = desc_words[ch * WORDS_PER_CH + WORD_SIZE];
      dst  = desc_words[ch * WORDS_PER_CH + WORD_DST];
      if (!ctrl[0]) return;
      unit_bytes = (ctrl[19] || ctrl[22]) ? 32'd4 : 32'd1;
      count = size[31] ? 32'd0 : size;
      lim = window_end(dst);
      if (lim != '0 && count != '0) begin
        fit = (lim - dst + unit_bytes - 32'd1) / unit_bytes;
        if (count > fit) begin
          count = fit;
          status_bits[ch] = 1'b1;
        end
      end
      units_moved[ch] = count[3:0];
      status_bits[DONE_LSB + ch] = 1'b1;
    endfunction

    function void note_access(cmd_e cmd, logic [8:0] off, logic [31:0] wdata);
      bus_resp_t   exp_r;
      logic        in_ch;
      logic [8:0]  rel;
      int unsigned widx;
      int unsigned c;
      exp_r.rd = '0;
      in_ch = ({1'b0, off} >= {1'b0, CH_BASE}) && ({1'b0, off} < CH_END);
      rel = off - CH_BASE;
      widx = 32'({2'b00, rel[8:2]});
      if (cmd == CMD_READ) begin
        if (off == OFF_CTRL) exp_r.rd = glob_ctrl;
        else if (off == OFF_ROUTE0) exp_r.rd = route_words[0];
        else if (off == OFF_ROUTE1) exp_r.rd = route_words[1];
        else if (off == OFF_STATUS) exp_r.rd = 32'(status_bits);
        else if (in_ch) exp_r.rd = desc_words[widx];
      end else if (off == OFF_CTRL) begin
        glob_ctrl = wdata;
        if (wdata[0]) foreach (desc_words[i]) desc_words[i] = '0;
      end else if (off == OFF_ROUTE0) begin
        route_words[0] = wdata;
      end else if (off == OFF_ROUTE1) begin
        route_words[1] = wdata;
      end else if (off == OFF_ABORT) begin
        for (c = 0; c < CHANNELS; c++) begin
          if (wdata[c]) begin
            desc_words[c * WORDS_PER_CH + WORD_CTRL][0] = 1'b0;
            status_bits[ABORT_LSB + c] = 1'b1;
          end
        end
      end else if (off == OFF_STATUS) begin
        status_bits &= ~wdata[STATUS_W-1:0];
      end else if (in_ch) begin
        desc_words[widx] = wdata;
        if (rel[4:0] == 5'd0) launch_transfer(32'({5'd0, rel[8:5]}));
      end
      exp_r.irq = (status_bits != '0);
      pending_resps.push_back(exp_r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_response(logic [31:0] rd, logic irq);
      bus_resp_t exp_r;
      if (pending_resps.size() == 0) begin
        report_mismatch($sformatf("unexpected item, read_data %h irq %b", rd, irq));
        return;
      end
      exp_r = pending_resps.pop_front();
      if (rd !== exp_r.rd)
        report_mismatch($sformatf("read_data %h, predicted %h", rd, exp_r.rd));
      if (irq !== exp_r.irq)
        report_mismatch($sformatf("irq %b, predicted %b", irq, exp_r.irq));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  cmd_e        command;
  logic [8:0]  offset;
  logic [31:0] write_data;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic        irq;

  dcrb_scoreboard sb;
  int unsigned    accepted_in;
  int unsigned    accepted_out;
  int unsigned    idle_cycles;
  int unsigned    issued;
  int unsigned    in_gap_max;
  int unsigned    out_gap_max;

  dma_channel_register_block_top uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .offset_i     (offset),
    .write_data_i (write_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data),
    .irq_o        (irq)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_access(command, offset, write_data);
        accepted_in++;
      end
      if (out_valid && !out_stall) begin
        sb.check_response(read_data, irq);
        accepted_out++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver side: random stall before each item
  initial begin
    int unsigned gap;
    int unsigned seen;
    out_stall = 1'b0;
    out_gap_max = 11;
    @(negedge clk);
    forever begin
      if ($urandom_range(39, 0) == 0) out_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 11;
      gap = $urandom_range(out_gap_max, 0);
      seen = accepted_out;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (accepted_out == seen);
    end
  end

  task automatic access(cmd_e cmd, logic [8:0] off, logic [31:0] wdata);
    int unsigned gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    offset     <= off;
    write_data <= wdata;
    issued++;
    do @(negedge clk); while (accepted_in < issued);
  endtask

  task automatic read_reg(logic [8:0] off);
    access(CMD_READ, off, $urandom);
  endtask

  task automatic write_reg(logic [8:0] off, logic [31:0] wdata);
    access(CMD_WRITE, off, wdata);
  endtask

  // descriptor setup followed by a control word write, which starts the channel unless bit 0 is clear
  task automatic program_transfer();
    int unsigned ch;
    logic [8:0]  base;
    logic [31:0] size, dst, ctrl;
    ch = $urandom_range(CHANNELS - 1, 0);
    base = 9'(CH_BASE + ch * 32);
    case ($urandom_range(4, 0))
      0: size = $urandom_range(15, 0);
      1: size = $urandom_range(80, 0);
      2: size = 32'h8000_0000 | $urandom;
      3: size = $urandom_range(32'hC000, 32'h2000);
      default: size = $urandom;
    endcase
    case ($urandom_range(6, 0))
      0: dst = WIN_A_HI - $urandom_range(64, 1);
      1: dst = WIN_B_HI - $urandom_range(64, 1);
      2: dst = WIN_A_LO + $urandom_range(32'hBFFF, 0);
      3: dst = WIN_B_LO + $urandom_range(32'h9FFF, 0);
      4: dst = ($urandom_range(1, 0) == 0) ? WIN_A_HI : WIN_B_LO - 32'd1;
      default: dst = $urandom;
    endcase
    ctrl = $urandom | 32'd1;
    if ($urandom_range(2, 0) == 0) ctrl &= ~((32'd1 << 19) | (32'd1 << 22));
    if ($urandom_range(5, 0) == 0) ctrl &= ~32'd1;
    write_reg(base + 9'h04, size);
    if ($urandom_range(3, 0) == 0) write_reg(base + 9'h08, $urandom);
    write_reg(base + 9'h10, dst);
    write_reg(base, ctrl);
    if ($urandom_range(1, 0) == 0) read_reg(OFF_STATUS);
    if ($urandom_range(2, 0) == 0) read_reg(base);
    if ($urandom_range(1, 0) == 0)
      write_reg(OFF_STATUS, ($urandom_range(1, 0) == 0) ? 32'hFFFF_FFFF : $urandom);
  endtask

  task automatic random_access();
    case ($urandom_range(7, 0))
      0: read_reg(9'($urandom_range(79, 8) * 4));
      1: write_reg(OFF_STATUS, $urandom);
      2: write_reg(OFF_ABORT, $urandom & $urandom);
      3: write_reg(OFF_CTRL, ($urandom_range(7, 0) == 0) ? ($urandom | 32'd1)
                                                          : ($urandom & ~32'd1));
      4: write_reg(($urandom_range(1, 0) == 0) ? OFF_ROUTE0 : OFF_ROUTE1, $urandom);
      5: access(cmd_e'($urandom_range(1, 0)), 9'($urandom), $urandom);
      6: write_reg(9'(CH_BASE + $urandom_range(255, 0)), $urandom);
      default: read_reg(9'(CH_BASE + $urandom_range(255, 0)));
    endcase
  endtask

  initial begin
    sb = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    command      = CMD_READ;
    offset       = '0;
    write_data   = '0;
    accepted_in  = 0;
    accepted_out = 0;
    idle_cycles  = 0;
    issued       = 0;
    in_gap_max   = 11;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    read_reg(OFF_ROUTE0);
    read_reg(OFF_CTRL);
    read_reg(OFF_STATUS);
    // exact fit at the end of the first ram window
    write_reg(9'h044, 32'd16);
    write_reg(9'h050, 32'h2000_BFF0);
    write_reg(9'h040, 32'h0000_0001);
    // word units overrun the window
    write_reg(9'h064, 32'd8);
    write_reg(9'h070, 32'h2000_BFF0);
    write_reg(9'h060, 32'h0008_0001);
    // negative size moves nothing
    write_reg(9'h084, 32'h8000_0000);
    write_reg(9'h080, 32'h0040_0001);
    // last channel, partial word at the end of the second window
    write_reg(9'h124, 32'h7FFF_FFFF);
    write_reg(9'h130, 32'h4012_9FFD);
    write_reg(9'h120, 32'h0048_0001);
    read_reg(OFF_STATUS);
    write_reg(OFF_ABORT, 32'hFFFF_FFFF);
    read_reg(OFF_ABORT);
    read_reg(9'h041);
    write_reg(OFF_STATUS, 32'hFFFF_FFFF);
    write_reg(OFF_ROUTE1, 32'hFFFF_FFFF);
    write_reg(9'h021, 32'h0000_0005);
    write_reg(OFF_CTRL, 32'hFFFF_FFFF);
    read_reg(9'h13C);
    read_reg(9'h140);
    write_reg(9'h1FF, $urandom);
    read_reg(OFF_ROUTE1);

    while (issued < ITEMS) begin
      if ($urandom_range(39, 0) == 0) in_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 11;
      if ($urandom_range(1, 0) == 0) program_transfer();
      else random_access();
    end
    in_valid <= 1'b0;

    while (sb.pending_resps.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
